// ===== sv/bmc_pkg.sv =====
// ----------------------------------------------------------------------------
// bmc_pkg
// Shared types and constants of the bank mapper with cycle IRQ counter.
// ----------------------------------------------------------------------------
`default_nettype none

package bmc_pkg;

    // Request kinds carried on the input tuser
    typedef enum logic [1:0] {
        OP_CPU_WRITE = 2'd0,
        OP_CYCLE_TICK = 2'd1,
        OP_CPU_READ = 2'd2,
        OP_PPU_READ = 2'd3
    } t_opcode;

    // Configuration register indexes
    localparam logic [7:0] CFG_PRG_BANK_MAX = 8'd0;
    localparam logic [7:0] CFG_CHR_BANK_MAX = 8'd1;

    localparam logic [7:0] PRG_BANK_MAX_RST = 8'd31;
    localparam logic [7:0] CHR_BANK_MAX_RST = 8'd255;

    localparam int PRG_SLOTS = 3;
    localparam int CHR_SLOTS = 8;
    localparam int CHR_SEL_W = $clog2(CHR_SLOTS);

    // CPU write pages, address bits [15:12]
    localparam logic [3:0] PAGE_RELOAD_N0 = 4'h8;
    localparam logic [3:0] PAGE_RELOAD_N1 = 4'h9;
    localparam logic [3:0] PAGE_RELOAD_N2 = 4'hA;
    localparam logic [3:0] PAGE_RELOAD_N3 = 4'hB;
    localparam logic [3:0] PAGE_ENABLE = 4'hC;
    localparam logic [3:0] PAGE_IRQ_ACK = 4'hD;
    localparam logic [3:0] PAGE_SELECT = 4'hE;
    localparam logic [3:0] PAGE_BANK = 4'hF;

    // Bank page sub-decode, address bits [11:10]
    localparam logic [1:0] SUB_PRG_HIGH = 2'b00;
    localparam logic [1:0] SUB_MIRROR = 2'b10;
    localparam logic [1:0] SUB_CHR = 2'b11;

    // Register select codes, low nibble
    localparam logic [3:0] SEL_PRG0 = 4'd1;
    localparam logic [3:0] SEL_PRG2 = 4'd3;
    localparam logic [3:0] SEL_RAM_WINDOW = 4'd4;

    localparam logic [15:0] COUNT_WRAP = 16'hFFFF;

    // Configuration write request
    typedef struct packed {
        logic       we;
        logic [7:0] index;
        logic [7:0] data;
    } t_cfg_write;

    // Result item; first field in the highest bits
    typedef struct packed {
        logic        address_mapped;
        logic [20:0] rom_address;
        logic        mirror_vertical;
        logic        irq_line;
    } t_result;

    // Mask a bank number by its maximum when it exceeds it
    function automatic logic [7:0] limit_bank(input logic [7:0] v, input logic [7:0] maxv);
        limit_bank = (v > maxv) ? (v & maxv) : v;
    endfunction

endpackage

`default_nettype wire

// ===== sv/bmc_core.sv =====
// ----------------------------------------------------------------------------
// bmc_core
// Mapper register file, IRQ counter and address translation for one request.
// ----------------------------------------------------------------------------
`default_nettype none

module bmc_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_fire,
    input  wire bmc_pkg::t_opcode   i_op,
    input  wire logic [15:0]        i_addr,
    input  wire logic [7:0]         i_data,
    input  wire bmc_pkg::t_cfg_write i_cfg,
    output bmc_pkg::t_result        o_result
);
    import bmc_pkg::*;

    logic [7:0]  r_prg_max, r_chr_max;
    logic [15:0] r_reload, n_reload;
    logic [15:0] r_counter, n_counter;
    logic        r_enabled, n_enabled;
    logic        r_pending, n_pending;
    logic [7:0]  r_select, n_select;
    logic [7:0]  r_prg [PRG_SLOTS];
    logic [7:0]  n_prg [PRG_SLOTS];
    logic [7:0]  r_ram_bank, n_ram_bank;
    logic [7:0]  r_chr [CHR_SLOTS];
    logic [7:0]  n_chr [CHR_SLOTS];
    logic        r_mirror, n_mirror;
    logic        r_irq, n_irq;

    logic [3:0]  nib;
    logic [1:0]  prg_idx;
    logic [7:0]  prg_val;
    logic [1:0]  rd_slot;

    assign nib = i_data[3:0];

    // Next state for one request
    always_comb begin
        n_reload = r_reload;
        n_counter = r_counter;
        n_enabled = r_enabled;
        n_pending = r_pending;
        n_select = r_select;
        n_prg = r_prg;
        n_ram_bank = r_ram_bank;
        n_chr = r_chr;
        n_mirror = r_mirror;
        n_irq = r_irq;
        prg_idx = '0;
        prg_val = '0;
        case (i_op)
            OP_CPU_WRITE: begin
                unique case (i_addr[15:12])
                    PAGE_RELOAD_N0: n_reload[3:0] = nib;
                    PAGE_RELOAD_N1: n_reload[7:4] = nib;
                    PAGE_RELOAD_N2: n_reload[11:8] = nib;
                    PAGE_RELOAD_N3: n_reload[15:12] = nib;
                    PAGE_ENABLE: begin
                        n_enabled = (nib != 4'd0);
                        if (n_enabled) begin
                            n_counter = r_reload;
                        end
                        n_irq = 1'b0;
                    end
                    PAGE_IRQ_ACK: n_irq = 1'b0;
                    PAGE_SELECT: n_select = i_data;
                    PAGE_BANK: begin
                        // Selected register: low nibble of a program slot, or the whole RAM window bank
                        if (r_select[3:0] >= SEL_PRG0 && r_select[3:0] <= SEL_PRG2) begin
                            prg_idx = 2'(r_select[3:0] - SEL_PRG0);
                            prg_val = (r_prg[prg_idx] & 8'h10) | {4'd0, nib};
                            n_prg[prg_idx] = limit_bank(prg_val, r_prg_max);
                        end else if (r_select[3:0] == SEL_RAM_WINDOW) begin
                            n_ram_bank = limit_bank(i_data, r_prg_max);
                        end
                        // Address-decoded part, on top of the selected update
                        case (i_addr[11:10])
                            SUB_PRG_HIGH: begin
                                if (i_addr[1:0] != 2'd3) begin
                                    prg_val = (i_data & 8'h10) | (n_prg[i_addr[1:0]] & 8'h0F);
                                    n_prg[i_addr[1:0]] = limit_bank(prg_val, r_prg_max);
                                end
                            end
                            SUB_MIRROR: n_mirror = i_data[0];
                            SUB_CHR: n_chr[i_addr[CHR_SEL_W-1:0]] =
                                limit_bank(i_data, r_chr_max);
                            default: ;
                        endcase
                    end
                    default: ;
                endcase
            end
            OP_CYCLE_TICK: begin
                if (r_pending) begin
                    n_pending = 1'b0;
                    n_irq = 1'b1;
                end
                if (r_enabled) begin
                    n_counter = r_counter + 16'd1;
                    if (n_counter == COUNT_WRAP) begin
                        n_counter = r_reload;
                        n_pending = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // Translate read addresses from the current banks
    always_comb begin
        o_result.rom_address = '0;
        o_result.address_mapped = 1'b0;
        rd_slot = i_addr[14:13];
        case (i_op)
            OP_CPU_READ: begin
                if (i_addr[15:13] == 3'b011) begin
                    o_result.rom_address = {r_ram_bank, i_addr[12:0]};
                    o_result.address_mapped = 1'b1;
                end else if (i_addr[15] && i_addr[14:13] != 2'b11) begin
                    o_result.rom_address = {r_prg[rd_slot], i_addr[12:0]};
                    o_result.address_mapped = 1'b1;
                end
            end
            OP_PPU_READ: begin
                if (i_addr[15:13] == 3'b000) begin
                    o_result.rom_address = {3'd0, r_chr[i_addr[12:10]], i_addr[9:0]};
                    o_result.address_mapped = 1'b1;
                end
            end
            default: ;
        endcase
        o_result.irq_line = n_irq;
        o_result.mirror_vertical = n_mirror;
    end

    // Hold mapper state; update on each processed request and on configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_max <= PRG_BANK_MAX_RST;
            r_chr_max <= CHR_BANK_MAX_RST;
            r_reload <= '0;
            r_counter <= '0;
            r_enabled <= 1'b0;
            r_pending <= 1'b0;
            r_select <= '0;
            for (int i = 0; i < PRG_SLOTS; i++) begin
                r_prg[i] <= '0;
            end
            r_ram_bank <= '0;
            for (int i = 0; i < CHR_SLOTS; i++) begin
                r_chr[i] <= '0;
            end
            r_mirror <= 1'b0;
            r_irq <= 1'b0;
        end else begin
            if (i_cfg.we && i_cfg.index == CFG_PRG_BANK_MAX) begin
                r_prg_max <= i_cfg.data;
            end
            if (i_cfg.we && i_cfg.index == CFG_CHR_BANK_MAX) begin
                r_chr_max <= i_cfg.data;
            end
            if (i_fire) begin
                r_reload <= n_reload;
                r_counter <= n_counter;
                r_enabled <= n_enabled;
                r_pending <= n_pending;
                r_select <= n_select;
                r_prg <= n_prg;
                r_ram_bank <= n_ram_bank;
                r_chr <= n_chr;
                r_mirror <= n_mirror;
                r_irq <= n_irq;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/bank_mapper_with_cycle_irq.sv =====
// A request is held in the input register, and its result moves to the output
// register once that register is free or its result is taken.
// Throughput: one request per cycle while results are taken; while a result
// waits for tready, a new request enters only if the input register is empty.
// Reset (i_rst_n low at a clock edge) clears all banks, the counter and IRQ,
// sets prg_bank_max to 31 and chr_bank_max to 255, and empties both stages.
// ----------------------------------------------------------------------------
// bank_mapper_with_cycle_irq
// Cartridge bank mapper with CPU-cycle IRQ counter, stream request interface.
// ----------------------------------------------------------------------------
`default_nettype none

module bank_mapper_with_cycle_irq (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [23:0] i_s_tdata,   // [15:0] bus_address, [23:16] write_data
    input  wire logic [1:0]  i_s_tuser,   // [1:0] opcode
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // [0] irq_line, [1] mirror_vertical, [22:2] rom_address, [23] address_mapped
    output logic [23:0]      o_m_tdata,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);
    import bmc_pkg::*;

    logic        r_in_valid;
    t_opcode     r_in_op;
    logic [15:0] r_in_addr;
    logic [7:0]  r_in_data;
    logic        r_out_valid;
    t_result     r_out;
    t_result     result;
    t_cfg_write  cfg;
    logic        advance;
    logic        fire;

    assign advance = !r_out_valid || i_m_tready;
    assign fire = r_in_valid && advance;
    assign o_s_tready = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    assign cfg.we = i_cfg_valid;
    assign cfg.index = i_cfg_index;
    assign cfg.data = i_cfg_data;

    bmc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_op     (r_in_op),
        .i_addr   (r_in_addr),
        .i_data   (r_in_data),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // Capture requests into the input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
        if (o_s_tready && i_s_tvalid) begin
            r_in_op <= t_opcode'(i_s_tuser);
            r_in_addr <= i_s_tdata[15:0];
            r_in_data <= i_s_tdata[23:16];
        end
    end

    // Advance results into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
        if (fire) begin
            r_out <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata = r_out;

endmodule

`default_nettype wire

// ===== sv/bmc_checker.sv =====
// ----------------------------------------------------------------------------
// bmc_checker
// Port-level checks of the bank mapper, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bmc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_s_tready,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [23:0] o_m_tdata
);

    // Output stage empties on reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    // Unmapped results carry a zero ROM address
    a_unmapped_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[23] |-> o_m_tdata[22:2] == 21'd0)
        else $error("unmapped result with nonzero address");

    // With the output free, requests are never refused
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output");

endmodule

bind bank_mapper_with_cycle_irq bmc_checker u_bmc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire
